FILE: hw/rtl/psbc_pkg.sv
`timescale 1ns / 1ps

package psbc_pkg;

    // Plane table geometry
    localparam int MAX_PLANES = 16;
    localparam int IDX_W      = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int CNT_W      = $clog2(MAX_PLANES + 1);
    localparam int PIDX_W     = 6;

    // Arithmetic widths (all Q.30 values)
    localparam int PROD_W = 48;   // Q1.14 x Q16.16, signed
    localparam int MAG_W  = 47;   // Q15.16 half-size x |normal|, unsigned
    localparam int M_W    = 50;   // signed distance of the centre
    localparam int N_W    = 48;   // projected extent
    localparam int SUM_W  = 51;   // m + n and m - n

    // Function codes of an input word
    localparam logic [1:0] FN_CLEAR  = 2'd0;
    localparam logic [1:0] FN_APPEND = 2'd1;
    localparam logic [1:0] FN_TEST   = 2'd2;

    typedef enum logic [2:0] {
        V_INSIDE    = 3'd0,
        V_INTERSECT = 3'd1,
        V_OUTSIDE   = 3'd2,
        V_STORED    = 3'd3,
        V_DROPPED   = 3'd4,
        V_CLEARED   = 3'd5
    } t_verdict;

    // Source of a pending result
    typedef enum logic [1:0] {
        RES_CLEAR,
        RES_APPEND,
        RES_EMPTY,
        RES_PLANE
    } t_res_sel;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic signed [31:0] off;
    } t_plane;

    // Controller to datapath
    typedef struct packed {
        logic     clear;
        logic     append;
        logic     start;
        logic     flush;
        logic     res_load;
        t_res_sel res_sel;
        logic     out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic done;
    } t_stat;

endpackage

FILE: hw/rtl/psbc_ctrl.sv
`timescale 1ns / 1ps

module psbc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_func,
    output logic                o_valid,
    input  logic                i_stall,
    input  psbc_pkg::t_stat     i_stat,
    output psbc_pkg::t_cmd      o_cmd
);

    psbc_pkg::t_state r_state, n_state;
    logic             r_out_v, n_out_v;

    // State and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psbc_pkg::ST_IDLE;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_v <= n_out_v;
        end
    end

    // Next state and commands
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.res_sel    = psbc_pkg::RES_CLEAR;
        n_out_v          = r_out_v && i_stall;

        unique case (r_state)
            psbc_pkg::ST_IDLE: begin
                if (i_valid) begin
                    case (i_func)
                        psbc_pkg::FN_CLEAR: begin
                            o_cmd.clear    = 1'b1;
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_sel  = psbc_pkg::RES_CLEAR;
                            n_state        = psbc_pkg::ST_HOLD;
                        end
                        psbc_pkg::FN_APPEND: begin
                            o_cmd.append   = 1'b1;
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_sel  = psbc_pkg::RES_APPEND;
                            n_state        = psbc_pkg::ST_HOLD;
                        end
                        psbc_pkg::FN_TEST: begin
                            o_cmd.start = 1'b1;
                            if (i_stat.cnt_zero) begin
                                o_cmd.res_load = 1'b1;
                                o_cmd.res_sel  = psbc_pkg::RES_EMPTY;
                                n_state        = psbc_pkg::ST_HOLD;
                            end else begin
                                n_state = psbc_pkg::ST_RUN;
                            end
                        end
                        default: ;  // unused code: word dropped, no result
                    endcase
                end
            end
            psbc_pkg::ST_RUN: begin
                // decision reached at the end of the pipeline
                if (i_stat.done) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = psbc_pkg::RES_PLANE;
                    o_cmd.flush    = 1'b1;
                    n_state        = psbc_pkg::ST_HOLD;
                end
            end
            psbc_pkg::ST_HOLD: begin
                // move the pending result once the output register is free
                if (!r_out_v || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_out_v        = 1'b1;
                    n_state        = psbc_pkg::ST_IDLE;
                end
            end
            default: n_state = psbc_pkg::ST_IDLE;
        endcase
    end

    assign o_stall = (r_state != psbc_pkg::ST_IDLE);
    assign o_valid = r_out_v;

endmodule

FILE: hw/rtl/psbc_dp.sv
`timescale 1ns / 1ps

module psbc_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  psbc_pkg::t_cmd      i_cmd,
    output psbc_pkg::t_stat     o_stat,
    input  logic signed [15:0]  i_normal_x,
    input  logic signed [15:0]  i_normal_y,
    input  logic signed [15:0]  i_normal_z,
    input  logic signed [31:0]  i_plane_offset,
    input  logic signed [31:0]  i_center_x,
    input  logic signed [31:0]  i_center_y,
    input  logic signed [31:0]  i_center_z,
    input  logic [30:0]         i_half_x,
    input  logic [30:0]         i_half_y,
    input  logic [30:0]         i_half_z,
    output logic [2:0]          o_verdict,
    output logic [5:0]          o_plane_index
);

    localparam int IDX_W = psbc_pkg::IDX_W;
    localparam int CNT_W = psbc_pkg::CNT_W;

    // Plane memory
    psbc_pkg::t_plane r_mem [psbc_pkg::MAX_PLANES];
    psbc_pkg::t_plane r_rd;

    // Control state
    logic [CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_iss;
    logic             r_issuing;
    logic             r_s1_v, r_s2_v, r_s3_v;
    logic             r_sticky;

    // Pipeline payload
    logic [IDX_W-1:0]          r_s1_idx, r_s2_idx, r_s3_idx;
    logic                      r_s1_last, r_s2_last, r_s3_last;
    logic signed [31:0]        r_cx, r_cy, r_cz;
    logic [30:0]               r_hx, r_hy, r_hz;
    logic signed [psbc_pkg::PROD_W-1:0] r_px, r_py, r_pz;
    logic [psbc_pkg::MAG_W-1:0]         r_qx, r_qy, r_qz;
    logic signed [31:0]        r_off;
    logic [psbc_pkg::M_W-1:0]  r_m;
    logic [psbc_pkg::N_W-1:0]  r_n;

    // Result registers
    psbc_pkg::t_verdict r_res_verdict, r_out_verdict;
    logic [IDX_W-1:0]   r_res_idx, r_out_idx;

    logic               full;
    logic               iss_last;
    logic [15:0]        ax, ay, az;
    logic [psbc_pkg::M_W-1:0]   n_m;
    logic [psbc_pkg::N_W-1:0]   n_n;
    logic [psbc_pkg::SUM_W-1:0] sum_p, sum_d;
    logic               outside, inter;

    assign full     = (r_cnt == CNT_W'(psbc_pkg::MAX_PLANES));
    assign iss_last = ({1'b0, r_iss} == CNT_W'(r_cnt - CNT_W'(1)));

    // Table writes and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.append && !full) begin
            r_mem[r_cnt[IDX_W-1:0]] <= '{nx: i_normal_x, ny: i_normal_y,
                                         nz: i_normal_z, off: i_plane_offset};
        end
        r_rd <= r_mem[r_iss];
    end

    // Plane count, issue counter, stage valids, intersect flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_iss     <= '0;
            r_issuing <= 1'b0;
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s3_v    <= 1'b0;
            r_sticky  <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_cnt <= '0;
            end else if (i_cmd.append && !full) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end

            if (i_cmd.start) begin
                r_iss     <= '0;
                r_issuing <= (r_cnt != '0);
                r_sticky  <= 1'b0;
            end else if (i_cmd.flush) begin
                r_issuing <= 1'b0;
            end else if (r_issuing) begin
                r_iss <= r_iss + IDX_W'(1);
                if (iss_last) begin
                    r_issuing <= 1'b0;
                end
            end

            if (r_s3_v && inter) begin
                r_sticky <= 1'b1;
            end

            if (i_cmd.flush) begin
                r_s1_v <= 1'b0;
                r_s2_v <= 1'b0;
                r_s3_v <= 1'b0;
            end else begin
                r_s1_v <= r_issuing;
                r_s2_v <= r_s1_v;
                r_s3_v <= r_s2_v;
            end
        end
    end

    // Normal magnitudes
    assign ax = r_rd.nx[15] ? (~r_rd.nx + 16'd1) : r_rd.nx;
    assign ay = r_rd.ny[15] ? (~r_rd.ny + 16'd1) : r_rd.ny;
    assign az = r_rd.nz[15] ? (~r_rd.nz + 16'd1) : r_rd.nz;

    // Distance and extent sums
    assign n_m = {{2{r_px[psbc_pkg::PROD_W-1]}}, r_px}
               + {{2{r_py[psbc_pkg::PROD_W-1]}}, r_py}
               + {{2{r_pz[psbc_pkg::PROD_W-1]}}, r_pz}
               + {{4{r_off[31]}}, r_off, 14'b0};
    assign n_n = {1'b0, r_qx} + {1'b0, r_qy} + {1'b0, r_qz};

    // Box pipeline payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_cx <= i_center_x;
            r_cy <= i_center_y;
            r_cz <= i_center_z;
            r_hx <= i_half_x;
            r_hy <= i_half_y;
            r_hz <= i_half_z;
        end
        // stage 1: memory read tag
        r_s1_idx  <= r_iss;
        r_s1_last <= iss_last;
        // stage 2: products
        r_px      <= r_rd.nx * r_cx;
        r_py      <= r_rd.ny * r_cy;
        r_pz      <= r_rd.nz * r_cz;
        r_qx      <= r_hx * ax;
        r_qy      <= r_hy * ay;
        r_qz      <= r_hz * az;
        r_off     <= r_rd.off;
        r_s2_idx  <= r_s1_idx;
        r_s2_last <= r_s1_last;
        // stage 3: sums
        r_m       <= n_m;
        r_n       <= n_n;
        r_s3_idx  <= r_s2_idx;
        r_s3_last <= r_s2_last;
    end

    // Plane tests on the sums
    assign sum_p   = {r_m[psbc_pkg::M_W-1], r_m} + {3'b000, r_n};
    assign sum_d   = {r_m[psbc_pkg::M_W-1], r_m} - {3'b000, r_n};
    assign outside = sum_p[psbc_pkg::SUM_W-1];
    assign inter   = sum_d[psbc_pkg::SUM_W-1];

    assign o_stat.cnt_zero = (r_cnt == '0);
    assign o_stat.done     = r_s3_v && (outside || r_s3_last);

    // Pending result and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            case (i_cmd.res_sel)
                psbc_pkg::RES_CLEAR: begin
                    r_res_verdict <= psbc_pkg::V_CLEARED;
                    r_res_idx     <= '0;
                end
                psbc_pkg::RES_APPEND: begin
                    r_res_verdict <= full ? psbc_pkg::V_DROPPED : psbc_pkg::V_STORED;
                    r_res_idx     <= full ? '0 : r_cnt[IDX_W-1:0];
                end
                psbc_pkg::RES_EMPTY: begin
                    r_res_verdict <= psbc_pkg::V_INSIDE;
                    r_res_idx     <= '0;
                end
                default: begin
                    if (outside) begin
                        r_res_verdict <= psbc_pkg::V_OUTSIDE;
                    end else if (r_sticky || inter) begin
                        r_res_verdict <= psbc_pkg::V_INTERSECT;
                    end else begin
                        r_res_verdict <= psbc_pkg::V_INSIDE;
                    end
                    r_res_idx <= r_s3_idx;
                end
            endcase
        end
        if (i_cmd.out_load) begin
            r_out_verdict <= r_res_verdict;
            r_out_idx     <= r_res_idx;
        end
    end

    assign o_verdict     = r_out_verdict;
    assign o_plane_index = psbc_pkg::PIDX_W'(r_out_idx);

endmodule

FILE: hw/rtl/plane_set_box_cull.sv
`timescale 1ns / 1ps
// Clear and append words: result goes to a pending register, then to the output register
// once it is free; no new word is taken meanwhile. Box test: planes issued one a cycle
// into a read/multiply/sum/compare pipeline, ending at the first rejecting plane or the
// last plane (an empty table gives inside directly); the next word waits for the result.
// Reset: synchronous, active low; plane count zero, pipeline and output empty,
// plane table contents undefined until written.

module plane_set_box_cull (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_func,
    input  logic signed [15:0] i_normal_x,
    input  logic signed [15:0] i_normal_y,
    input  logic signed [15:0] i_normal_z,
    input  logic signed [31:0] i_plane_offset,
    input  logic signed [31:0] i_center_x,
    input  logic signed [31:0] i_center_y,
    input  logic signed [31:0] i_center_z,
    input  logic [30:0]        i_half_x,
    input  logic [30:0]        i_half_y,
    input  logic [30:0]        i_half_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [2:0]         o_verdict,
    output logic [5:0]         o_plane_index
);

    psbc_pkg::t_cmd  cmd;
    psbc_pkg::t_stat stat;

    // Sequencer
    psbc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_func  (i_func),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Plane table and test pipeline
    psbc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_normal_x     (i_normal_x),
        .i_normal_y     (i_normal_y),
        .i_normal_z     (i_normal_z),
        .i_plane_offset (i_plane_offset),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_center_z     (i_center_z),
        .i_half_x       (i_half_x),
        .i_half_y       (i_half_y),
        .i_half_z       (i_half_z),
        .o_verdict      (o_verdict),
        .o_plane_index  (o_plane_index)
    );

endmodule
